// ===== rtl/swrms_pkg.sv =====
// ----------------------------------------------------------------------------
// swrms_pkg
// Shared types and constants for the moving-window RMS block.
// ----------------------------------------------------------------------------
package swrms_pkg;

   // Sample and square widths (Q1.15 in, unsigned Q1.30 square)
   localparam int SAMPLE_W = 16;
   localparam int SQ_W     = 31;
   // Mean square never exceeds 2^30, whatever the window length
   localparam int MEAN_W   = 31;
   localparam int ROOT_W   = 16;
   // Signed difference of two squares
   localparam int DIFF_W   = 32;
   // Root unit: one result bit per step
   localparam int ROOT_STEPS = 16;
   localparam int STEP_W     = 4;
   // Job queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = 1;
   localparam int Q_CW    = 2;

   // One job handed from the front to the root unit
   typedef struct packed {
      logic [MEAN_W-1:0] mean;
      logic              full;
   } swrms_job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic empty;
      logic full;
   } swrms_qstat_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_MULT,
      FRONT_DIFF,
      FRONT_ACC
   } front_state_type;

   typedef enum logic [1:0] {
      ROOT_IDLE,
      ROOT_RUN,
      ROOT_DONE
   } root_state_type;

endpackage

// ===== rtl/swrms_front.sv =====
// ----------------------------------------------------------------------------
// swrms_front
// Accepts samples, keeps the sample ring and the running sum of squares,
// and pushes the mean square with the window-full flag into the job queue.
// ----------------------------------------------------------------------------
module swrms_front import swrms_pkg::*; #(
   parameter int WINDOW = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  swrms_qstat_type     q_stat,
   output logic                q_push,
   output swrms_job_type       q_job
);

   localparam int LOG_W = $clog2(WINDOW);
   localparam int SUM_W = SQ_W + LOG_W;

   front_state_type state_ff, state_in;

   logic [LOG_W-1:0]    wr_pos_ff;
   logic                filled_ff;
   logic                item_full_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] old_ff;
   logic [SQ_W-1:0]     new_sq_ff;
   logic [SQ_W-1:0]     old_sq_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] ring_mem [WINDOW];

   logic                accept;
   logic [SAMPLE_W-1:0] new_mag;
   logic [SAMPLE_W-1:0] old_mag;
   logic [2*SAMPLE_W-1:0] new_prod;
   logic [2*SAMPLE_W-1:0] old_prod;

   assign accept = req_valid && !req_stall;

   // Next state and handshake
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      q_push    = 1'b0;
      unique case (state_ff)
         FRONT_IDLE: begin
            req_stall = q_stat.full;
            if (req_valid && !q_stat.full) begin
               state_in = FRONT_MULT;
            end
         end
         FRONT_MULT: begin
            state_in = FRONT_DIFF;
         end
         FRONT_DIFF: begin
            state_in = FRONT_ACC;
         end
         FRONT_ACC: begin
            q_push   = 1'b1;
            state_in = FRONT_IDLE;
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Ring: read the oldest entry and overwrite it with the new item
   always_ff @(posedge clock) begin
      if (accept) begin
         old_ff              <= ring_mem[wr_pos_ff];
         ring_mem[wr_pos_ff] <= req_sample;
      end
   end

   // Advance the write position and note the first wrap
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         filled_ff <= 1'b0;
      end else if (accept) begin
         wr_pos_ff <= wr_pos_ff + 1'b1;
         if (wr_pos_ff == LOG_W'(WINDOW - 1)) begin
            filled_ff <= 1'b1;
         end
      end
   end

   // Hold the item and the flag as it stood before this item
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff    <= req_sample;
         item_full_ff <= filled_ff;
      end
   end

   // Magnitudes; the most negative sample maps to 0x8000
   assign new_mag  = sample_ff[SAMPLE_W-1] ? (~sample_ff + 1'b1) : sample_ff;
   assign old_mag  = old_ff[SAMPLE_W-1] ? (~old_ff + 1'b1) : old_ff;
   assign new_prod = new_mag * new_mag;
   assign old_prod = old_mag * old_mag;

   // Square both samples; drop the old one while the window is filling
   always_ff @(posedge clock) begin
      if (state_ff == FRONT_MULT) begin
         new_sq_ff <= new_prod[SQ_W-1:0];
         old_sq_ff <= item_full_ff ? old_prod[SQ_W-1:0] : '0;
      end
   end

   // Difference of the two squares
   always_ff @(posedge clock) begin
      if (state_ff == FRONT_DIFF) begin
         diff_ff <= $signed({1'b0, new_sq_ff}) - $signed({1'b0, old_sq_ff});
      end
   end

   // Running sum of squares
   assign sum_in = sum_ff + SUM_W'(diff_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (state_ff == FRONT_ACC) begin
         sum_ff <= sum_in;
      end
   end

   // Mean square is a plain shift of the new sum
   assign q_job.mean = sum_in[LOG_W +: MEAN_W];
   assign q_job.full = item_full_ff;

endmodule

// ===== rtl/swrms_queue.sv =====
// ----------------------------------------------------------------------------
// swrms_queue
// Short job queue between the front and the root unit.
// ----------------------------------------------------------------------------
module swrms_queue import swrms_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  swrms_job_type   push_job,
   input  logic            pop,
   output swrms_job_type   pop_job,
   output swrms_qstat_type stat
);

   swrms_job_type    entry_ff [Q_DEPTH];
   logic [Q_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0]  count_ff, count_in;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == Q_CW'(Q_DEPTH));
   assign pop_job    = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/swrms_root.sv =====
// ----------------------------------------------------------------------------
// swrms_root
// Iterative floor square root, one result bit per cycle, with the result
// register of the output channel.
// ----------------------------------------------------------------------------
module swrms_root import swrms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  swrms_qstat_type   q_stat,
   input  swrms_job_type     q_job,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ROOT_W-1:0] rsp_rms_value,
   output logic              rsp_window_full
);

   root_state_type state_ff, state_in;

   logic [MEAN_W-1:0] rem_ff, rem_in;
   logic [MEAN_W:0]   root_ff, root_in;
   logic [MEAN_W-1:0] bit_ff, bit_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              full_ff, full_in;

   logic              out_valid_ff, out_valid_in;
   logic [ROOT_W-1:0] out_rms_ff, out_rms_in;
   logic              out_full_ff, out_full_in;

   logic              slot_free;
   logic [MEAN_W:0]   trial;

   assign slot_free = !out_valid_ff || !rsp_stall;
   assign trial     = root_ff + {1'b0, bit_ff};

   // Sequencer and one root step per cycle
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      step_in      = step_ff;
      full_in      = full_ff;
      q_pop        = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      out_rms_in   = out_rms_ff;
      out_full_in  = out_full_ff;
      unique case (state_ff)
         ROOT_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               rem_in   = q_job.mean;
               full_in  = q_job.full;
               root_in  = '0;
               // Start from the top power of four that the mean can reach
               bit_in   = {1'b1, {(MEAN_W-1){1'b0}}};
               step_in  = '0;
               state_in = ROOT_RUN;
            end
         end
         ROOT_RUN: begin
            if ({1'b0, rem_ff} >= trial) begin
               rem_in  = rem_ff - trial[MEAN_W-1:0];
               root_in = (root_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = ROOT_DONE;
            end
         end
         ROOT_DONE: begin
            // Hold the result until the output register is free
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_rms_in   = full_ff ? root_ff[ROOT_W-1:0] : '0;
               out_full_in  = full_ff;
               state_in     = ROOT_IDLE;
            end
         end
         default: begin
            state_in = ROOT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ROOT_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      step_ff     <= step_in;
      full_ff     <= full_in;
      out_rms_ff  <= out_rms_in;
      out_full_ff <= out_full_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_rms_value   = out_rms_ff;
   assign rsp_window_full = out_full_ff;

endmodule

// ===== rtl/sliding_window_rms.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rms
// Moving-window RMS of a signed Q1.15 sample stream: running sum of squares
// over the last WINDOW items, mean by shift, floor square root.
// ----------------------------------------------------------------------------
//   Channel   Ports                                      Direction
//   req       req_valid, req_stall, req_sample           in
//   rsp       rsp_valid, rsp_stall, rsp_rms_value,       out
//             rsp_window_full
//
// The front reads the ring, squares, forms the difference and accumulates
// before it takes the next item; the 16-step root unit sets the sustained
// rate. A two-entry job queue sits between them.
// Reset clears the sum, write position, fill flag, queue and output valid;
// the ring needs no clearing, as its old entries count only once it is full.
// A stalled result is held in the output register while the front goes on.
// ----------------------------------------------------------------------------
module sliding_window_rms import swrms_pkg::*; #(
   parameter int WINDOW = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ROOT_W-1:0]   rsp_rms_value,
   output logic                rsp_window_full
);

   swrms_qstat_type q_stat;
   swrms_job_type   push_job;
   swrms_job_type   pop_job;
   logic            q_push;
   logic            q_pop;

   // Accept items and keep the window sum
   swrms_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   // Decouple the two sides
   swrms_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .stat     (q_stat)
   );

   // Square root and result register
   swrms_root u_root (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .q_job           (pop_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rms_value   (rsp_rms_value),
      .rsp_window_full (rsp_window_full)
   );

endmodule
